### sv/moving_average_deadband_thermometer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the moving average deadband thermometer
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_DEADBAND_THERMOMETER_DEFINES_SVH
`define MOVING_AVERAGE_DEADBAND_THERMOMETER_DEFINES_SVH
`ifndef SYNTH
`define MADT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MADT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MADT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MADT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### sv/mavgdt_pkg.sv
// ---------------------------------------------------------------------------
// mavgdt_pkg
// Shared widths, reset values, register indexes and types.
// ---------------------------------------------------------------------------
package mavgdt_pkg;

   localparam int WINDOW_DEF      = 50;
   localparam int SAMPLE_BITS_DEF = 10;

   localparam int AVG_W      = 10;
   localparam int TEMP_W     = 20;
   localparam int GAIN_W     = 10;
   localparam int DEADBAND_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [AVG_W-1:0]      AVG_MAX        = '1;
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = GAIN_W'(500);
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(819);

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_DEADBAND = CSR_ADDR_W'(1);

   typedef struct packed {
      logic [GAIN_W-1:0]     gain;
      logic [DEADBAND_W-1:0] deadband;
   } cfg_type;

   function automatic int sum_width(input int window, input int bits);
      return $clog2(window * ((1 << bits) - 1) + 1);
   endfunction

endpackage

### sv/moving_average_deadband_thermometer.sv
// Each result passes the window sum register, two divider stages and two scaling stages before rsp_valid.
// Throughput: one transaction per cycle while rsp_stall does not hold the pipeline,
// set by the running sum and the history RAM read ahead of the ring position.
// Reset (synchronous): clears history valid flags, window sum, held value and
// pipeline valids; gain returns to 500 and deadband to 819. No clearing pass.
// ---------------------------------------------------------------------------
// moving_average_deadband_thermometer
// Boxcar moving average of converter samples, scaled to temperature, with a
// deadband hold on the displayed value.
// ---------------------------------------------------------------------------
`include "moving_average_deadband_thermometer_defines.svh"

module moving_average_deadband_thermometer import mavgdt_pkg::*; #(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [AVG_W-1:0]       rsp_average,
   output logic [TEMP_W-1:0]      rsp_temperature,
   output logic [TEMP_W-1:0]      rsp_shown_value,
   output logic                   rsp_updated,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SUM_W = sum_width(WINDOW, SAMPLE_BITS);
   localparam int EXT_W = TEMP_W + 1;
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_BITS) - 1));

   cfg_type          cfg_ff, cfg_in;
   logic             req_ready;
   logic             sum_valid, sum_ready, avg_valid, avg_ready;
   logic [SUM_W-1:0] sum;
   logic [AVG_W-1:0] avg;
   logic [EXT_W-1:0] chk_t_plus_d, chk_s_plus_d;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN:     cfg_in.gain     = csr_data[GAIN_W-1:0];
            CSR_DEADBAND: cfg_in.deadband = csr_data[DEADBAND_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain     <= GAIN_RESET;
         cfg_ff.deadband <= DEADBAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !req_ready;

   mavgdt_window #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum)
   );

   mavgdt_divide #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sum),
      .out_valid (avg_valid),
      .out_ready (avg_ready),
      .out_avg   (avg)
   );

   mavgdt_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (avg_valid),
      .in_ready    (avg_ready),
      .in_avg      (avg),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_avg     (rsp_average),
      .out_temp    (rsp_temperature),
      .out_shown   (rsp_shown_value),
      .out_updated (rsp_updated)
   );

   assign chk_t_plus_d = EXT_W'(rsp_temperature) + EXT_W'(cfg_ff.deadband);
   assign chk_s_plus_d = EXT_W'(rsp_shown_value) + EXT_W'(cfg_ff.deadband);

   `MADT_ASSERT_IMPLY(a_sum_bound, clock, reset, sum_valid, sum <= SUM_MAX, "window sum out of range")
   `MADT_ASSERT_IMPLY(a_upd_takes_temp, clock, reset, rsp_valid && rsp_updated, rsp_shown_value == rsp_temperature, "updated value differs from temperature")
   `MADT_ASSERT_NEXT(a_hold_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_shown_value), "held value moved under stall")
   `MADT_ASSERT_IMPLY(a_hold_in_band, clock, reset, rsp_valid && !rsp_updated && !$changed(cfg_ff), (chk_t_plus_d >= EXT_W'(rsp_shown_value)) && (EXT_W'(rsp_temperature) <= chk_s_plus_d), "held value outside deadband")

endmodule

### sv/mavgdt_ram.sv
// ---------------------------------------------------------------------------
// mavgdt_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module mavgdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mavgdt_window.sv
// ---------------------------------------------------------------------------
// mavgdt_window
// Sample history ring and running window sum.
// ---------------------------------------------------------------------------
module mavgdt_window import mavgdt_pkg::*; #(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SUM_W = sum_width(WINDOW, SAMPLE_BITS),
   localparam int IDX_W = $clog2(WINDOW)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SUM_W-1:0]       out_sum
);

   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [WINDOW-1:0]      valid_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in, sum_out_ff;
   logic                   out_valid_ff;
   logic [SAMPLE_BITS-1:0] rd_data, oldest;
   logic                   accept;

   assign in_ready = !out_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // read ahead: the slot for the next transaction is fetched from the next ring position
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (pos_ff == IDX_W'(WINDOW - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign oldest = valid_ff[pos_ff] ? rd_data : '0;
   assign sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(in_sample);

   mavgdt_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (in_sample),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         valid_ff     <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (accept) begin
            valid_ff[pos_ff] <= 1'b1;
            sum_ff           <= sum_in;
         end
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sum_out_ff <= sum_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_sum   = sum_out_ff;

endmodule

### sv/mavgdt_divide.sv
// ---------------------------------------------------------------------------
// mavgdt_divide
// Window sum divided by the window length: reciprocal estimate, then one
// remainder correction and saturation to the average field.
// ---------------------------------------------------------------------------
module mavgdt_divide import mavgdt_pkg::*; #(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SUM_W = sum_width(WINDOW, SAMPLE_BITS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [SUM_W-1:0] in_sum,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [AVG_W-1:0] out_avg
);

   localparam int PROD_W = 2 * SUM_W;
   localparam int CMP_W  = (SUM_W > AVG_W) ? SUM_W : AVG_W;
   localparam logic [SUM_W-1:0] RECIP_C = SUM_W'((2 ** SUM_W) / WINDOW);
   localparam logic [SUM_W-1:0] WIN_C   = SUM_W'(WINDOW);

   logic              s1_valid_ff, s2_valid_ff, s2_ready;
   logic [SUM_W-1:0]  s1_qest_ff, s1_sum_ff;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  wmul, rem, quot;
   logic [CMP_W-1:0]  quot_wide;
   logic [AVG_W-1:0]  avg_in, avg_ff;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s2_ready;

   // estimate is exact or one low
   assign prod = PROD_W'(in_sum) * PROD_W'(RECIP_C);

   assign wmul      = s1_qest_ff * WIN_C;
   assign rem       = s1_sum_ff - wmul;
   assign quot      = s1_qest_ff + SUM_W'(rem >= WIN_C);
   assign quot_wide = CMP_W'(quot);
   assign avg_in    = (quot_wide > CMP_W'(AVG_MAX)) ? AVG_MAX : AVG_W'(quot_wide);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_qest_ff <= prod[PROD_W-1:SUM_W];
         s1_sum_ff  <= in_sum;
      end
      if (s2_ready && s1_valid_ff) begin
         avg_ff <= avg_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_avg   = avg_ff;

endmodule

### sv/mavgdt_scale.sv
// ---------------------------------------------------------------------------
// mavgdt_scale
// Gain scaling to temperature and deadband hold of the displayed value.
// ---------------------------------------------------------------------------
module mavgdt_scale import mavgdt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [AVG_W-1:0]  in_avg,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [AVG_W-1:0]  out_avg,
   output logic [TEMP_W-1:0] out_temp,
   output logic [TEMP_W-1:0] out_shown,
   output logic              out_updated
);

   localparam int EXT_W = TEMP_W + 1;

   logic              a_valid_ff, b_valid_ff, b_ready, b_load;
   logic [AVG_W-1:0]  a_avg_ff, b_avg_ff;
   logic [TEMP_W-1:0] a_temp_ff, b_temp_ff, held_ff, held_in;
   logic              b_upd_ff, change;
   logic [EXT_W-1:0]  band_hi, temp_plus_d;

   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || b_ready;
   assign b_load   = b_ready && a_valid_ff;

   assign band_hi     = EXT_W'(held_ff) + EXT_W'(cfg.deadband);
   assign temp_plus_d = EXT_W'(a_temp_ff) + EXT_W'(cfg.deadband);
   assign change      = (EXT_W'(a_temp_ff) > band_hi) || (temp_plus_d < EXT_W'(held_ff));
   assign held_in     = change ? a_temp_ff : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (b_load) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_avg_ff  <= in_avg;
         a_temp_ff <= TEMP_W'(in_avg) * TEMP_W'(cfg.gain);
      end
      if (b_load) begin
         b_avg_ff  <= a_avg_ff;
         b_temp_ff <= a_temp_ff;
         b_upd_ff  <= change;
      end
   end

   assign out_valid   = b_valid_ff;
   assign out_avg     = b_avg_ff;
   assign out_temp    = b_temp_ff;
   assign out_shown   = held_ff;
   assign out_updated = b_upd_ff;

endmodule

### bench/madt_reading_checker.sv
// ---------------------------------------------------------------------------
// madt_reading_checker
// Watches the request, result and register channels of the moving average
// deadband thermometer. Keeps its own sample ring, running sum, held display
// value and gain/deadband settings, and predicts one reading for each
// accepted request transaction. Each accepted result transaction is compared
// field by field with the oldest predicted reading.
// ---------------------------------------------------------------------------
module madt_reading_checker import mavgdt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [SAMPLE_BITS_DEF-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [AVG_W-1:0]           rsp_average,
   input  logic [TEMP_W-1:0]          rsp_temperature,
   input  logic [TEMP_W-1:0]          rsp_shown_value,
   input  logic                       rsp_updated,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_ADDR_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         errors,
   output int                         outstanding
);

   localparam int SUM_W      = sum_width(WINDOW_DEF, SAMPLE_BITS_DEF);
   localparam int TEMP_MAX   = (1 << TEMP_W) - 1;

   typedef struct packed {
      logic [AVG_W-1:0]  average;
      logic [TEMP_W-1:0] temperature;
      logic [TEMP_W-1:0] shown_value;
      logic              updated;
   } reading_type;

   logic [SAMPLE_BITS_DEF-1:0] ring [WINDOW_DEF];
   int unsigned                ring_pos;
   logic [SUM_W-1:0]           ring_sum;
   logic [TEMP_W-1:0]          held_temp;
   cfg_type                    cfg;
   reading_type                awaited_readings [$];

   task automatic flag_error(input string msg);
      $display("%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic void clear_filter();
      foreach (ring[i]) ring[i] = '0;
      ring_pos     = 0;
      ring_sum     = '0;
      held_temp    = '0;
      cfg.gain     = GAIN_RESET;
      cfg.deadband = DEADBAND_RESET;
   endfunction

   function automatic reading_type filter_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
      reading_type r;
      int unsigned mean;
      int unsigned scaled;
      int          hi_edge;
      int          lo_edge;
      ring_sum = ring_sum - ring[ring_pos] + s;
      ring[ring_pos] = s;
      ring_pos = (ring_pos == WINDOW_DEF - 1) ? 0 : ring_pos + 1;
      mean = ring_sum / WINDOW_DEF;
      if (mean > AVG_MAX) mean = AVG_MAX;
      scaled = mean * cfg.gain;
      if (scaled > TEMP_MAX) scaled = TEMP_MAX;
      // lower edge may go negative; signed compare keeps it from firing
      hi_edge = int'(held_temp) + int'(cfg.deadband);
      lo_edge = int'(held_temp) - int'(cfg.deadband);
      r.updated = (int'(scaled) > hi_edge) || (int'(scaled) < lo_edge);
      if (r.updated) held_temp = scaled[TEMP_W-1:0];
      r.average     = mean[AVG_W-1:0];
      r.temperature = scaled[TEMP_W-1:0];
      r.shown_value = held_temp;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         clear_filter();
         awaited_readings.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN: begin
                  cfg.gain = csr_data[GAIN_W-1:0];
               end
               CSR_DEADBAND: begin
                  cfg.deadband = csr_data[DEADBAND_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_readings.size() == 0) begin
               flag_error($sformatf("unexpected result transaction, average %0d", rsp_average));
            end else begin
               want = awaited_readings.pop_front();
               if (rsp_average !== want.average)
                  flag_error($sformatf("average %0d, expected %0d",
                                       rsp_average, want.average));
               if (rsp_temperature !== want.temperature)
                  flag_error($sformatf("temperature %0d, expected %0d",
                                       rsp_temperature, want.temperature));
               if (rsp_shown_value !== want.shown_value)
                  flag_error($sformatf("shown_value %0d, expected %0d",
                                       rsp_shown_value, want.shown_value));
               if (rsp_updated !== want.updated)
                  flag_error($sformatf("updated %0b, expected %0b",
                                       rsp_updated, want.updated));
            end
         end
         if (req_valid && !req_stall) awaited_readings.push_back(filter_sample(req_sample));
      end
      outstanding <= awaited_readings.size();
   end

endmodule

### bench/tb_moving_average_deadband_thermometer.sv
// ---------------------------------------------------------------------------
// tb_moving_average_deadband_thermometer
// Drives converter samples into the thermometer under several gain and
// deadband settings, with random idle bursts on both channels, and lets the
// reading checker compare every result transaction. A watchdog ends the run
// when no transaction moves for too long.
// ---------------------------------------------------------------------------
module tb_moving_average_deadband_thermometer;
   import mavgdt_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS_DEF) - 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_A = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_B = CSR_ADDR_W'(3);

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   logic [SAMPLE_BITS_DEF-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b0;
   logic [AVG_W-1:0]           rsp_average;
   logic [TEMP_W-1:0]          rsp_temperature;
   logic [TEMP_W-1:0]          rsp_shown_value;
   logic                       rsp_updated;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_ADDR_W-1:0]      csr_index  = '0;
   logic [CSR_DATA_W-1:0]      csr_data   = '0;

   int errors;
   int outstanding;
   int gap_odds   = 4;
   int stall_odds = 5;
   int level      = 512;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   moving_average_deadband_thermometer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_temperature (rsp_temperature),
      .rsp_shown_value (rsp_shown_value),
      .rsp_updated     (rsp_updated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   madt_reading_checker reading_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_temperature (rsp_temperature),
      .rsp_shown_value (rsp_shown_value),
      .rsp_updated     (rsp_updated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .errors          (errors),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[moving_average_deadband_thermometer] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] value);
      if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input int unsigned gain_value, input int unsigned band_value);
      logic [CSR_DATA_W-1:0] gain_word;
      gain_word = CSR_DATA_W'($urandom);
      gain_word[GAIN_W-1:0] = gain_value[GAIN_W-1:0];
      drain();
      write_register(CSR_GAIN, gain_word);
      write_register(CSR_DEADBAND, band_value[CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // mostly a slowly moving level with small noise, plus steps, noise and rails
   task automatic run_random(input int count);
      int pick;
      int value;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 24) == 0) level = $urandom_range(0, SAMPLE_MAX);
         pick = $urandom_range(0, 9);
         if (pick < 6) value = level + int'($urandom_range(0, 16)) - 8;
         else if (pick < 8) value = $urandom_range(0, SAMPLE_MAX);
         else if (pick == 8) value = 0;
         else value = SAMPLE_MAX;
         if (value < 0) value = 0;
         if (value > SAMPLE_MAX) value = SAMPLE_MAX;
         send_sample(value[SAMPLE_BITS_DEF-1:0]);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: rails, alternating bits, a run at full scale, then back to zero
      send_sample('0);
      send_sample('1);
      send_sample(SAMPLE_BITS_DEF'(10'h155));
      send_sample(SAMPLE_BITS_DEF'(10'h2AA));
      repeat (16) send_sample('1);
      repeat (4) send_sample('0);

      // writes to unused indexes must leave the settings alone
      drain();
      write_register(CSR_SPARE_A, CSR_DATA_W'($urandom));
      write_register(CSR_SPARE_B, '1);
      csr_valid <= 1'b0;
      run_random(80);

      apply_setting(1023, 65535);
      run_random(70);

      gap_odds   = 0;
      stall_odds = 0;
      apply_setting(0, 0);
      run_random(40);

      gap_odds   = 3;
      stall_odds = 3;
      apply_setting(1023, 0);
      run_random(70);

      apply_setting(1, 1);
      run_random(50);

      gap_odds   = 6;
      stall_odds = 2;
      apply_setting($urandom_range(0, 1023), $urandom_range(0, 3000));
      run_random(70);

      gap_odds   = 0;
      stall_odds = 0;
      apply_setting(GAIN_RESET, DEADBAND_RESET);
      run_random(60);

      drain();
      if (errors == 0 && outstanding == 0) begin
         $display("[moving_average_deadband_thermometer] OK");
      end else begin
         $display("[moving_average_deadband_thermometer] ERROR");
      end
      $finish;
   end

endmodule
